@@ hdl/epe_pkg.sv @@
package epe_pkg;

	// Fraction table depth of the exponential (64 .. 4096)
	localparam int FRAC_TABLE_DEPTH = 256;
	localparam int FRAC_IDX_W = $clog2(FRAC_TABLE_DEPTH);

	// Squared-radius saturation value, 2^47 - 1 in Q.16
	localparam logic [46:0] RSQ_CAP = {47{1'b1}};

	typedef enum logic [2:0] {
		REG_MODE        = 3'd0,
		REG_CENTER_X    = 3'd1,
		REG_CENTER_Y    = 3'd2,
		REG_COS_ANGLE   = 3'd3,
		REG_SIN_ANGLE   = 3'd4,
		REG_INV_Q_SQ    = 3'd5,
		REG_AMPLITUDE   = 3'd6,
		REG_SHAPE_PARAM = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic               mode;        // 0 top-hat, 1 Gaussian
		logic signed [31:0] center_x;    // Q16.16
		logic signed [31:0] center_y;    // Q16.16
		logic signed [15:0] cos_angle;   // Q1.14
		logic signed [15:0] sin_angle;   // Q1.14
		logic        [24:0] inv_q_sq;    // Q9.16
		logic        [15:0] amplitude;
		logic        [31:0] shape_param; // Q16.16
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		mode:        1'b1,
		center_x:    32'sd0,
		center_y:    32'sd0,
		cos_angle:   16'sd16384,
		sin_angle:   16'sd0,
		inv_q_sq:    25'd65536,
		amplitude:   16'd0,
		shape_param: 32'd0
	};

	// exp(-i) in Q0.16, i = 0 .. 15
	localparam logic [16:0] INT_EXP_TAB [16] = '{
		17'd65536, 17'd24109, 17'd8869, 17'd3263, 17'd1200, 17'd442, 17'd162, 17'd60,
		17'd22,    17'd8,     17'd3,    17'd1,    17'd0,    17'd0,   17'd0,   17'd0
	};

	typedef logic [16:0] frac_tab_t [FRAC_TABLE_DEPTH];

	// round(exp(-n/DEPTH) * 65536), Taylor series in Q.31, built at elaboration
	function automatic frac_tab_t build_frac_tab();
		frac_tab_t   tab;
		logic [63:0] xq;
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg;
		for (int n = 0; n < FRAC_TABLE_DEPTH; n++) begin
			if (n == 0) begin
				tab[n] = 17'd65536;
			end else begin
				xq   = (64'(n) << 31) / 64'(FRAC_TABLE_DEPTH);
				term = 64'd1 << 31;
				pos  = term;
				neg  = 64'd0;
				for (int j = 1; j <= 24; j++) begin
					term = ((term * xq) >> 31) / 64'(j);
					if ((j & 1) != 0) begin
						neg = neg + term;
					end else begin
						pos = pos + term;
					end
				end
				if (neg >= pos) begin
					tab[n] = 17'd0;
				end else begin
					tab[n] = 17'(((pos - neg) + (64'd1 << 14)) >> 15);
				end
			end
		end
		return tab;
	endfunction

	localparam frac_tab_t FRAC_EXP_TAB = build_frac_tab();

endpackage

@@ hdl/elliptical_profile_evaluator.sv @@
// Elliptical profile evaluator: surface brightness of an elliptical top-hat
// or Gaussian profile at a pixel position.
// Input channel s_*: one beat per pixel, s_tdata = {y_pos, x_pos}, both
// signed Q16.16. Output channel m_*: one beat per pixel, in order,
// m_tdata = brightness (16-bit unsigned, saturated).
// Configuration: cfg_we / cfg_addr / cfg_wdata write one register per clock
// edge, no read-back; write only while no pixel is in flight.
// Throughput: one pixel per cycle unless the output is held; each of the 11
// stages holds one beat, and the slowest steps are the 38x25 inverse-axis
// multiply and the two-part 36x32 exponent product.
// Stall: each stage loads when empty or when the stage after it loads, so a
// held output compresses bubbles and s_tready stays high until every stage
// holds a beat. Nothing is dropped or repeated.
// Reset (arst_n low): all stages empty, registers take their reset values
// (Gaussian mode, unit cosine, zero amplitude).
// Exponential: exp(-t) = E_int[t>>16] * E_frac[fraction index], both Q0.16;
// a t of 16 or more gives zero.
module elliptical_profile_evaluator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] x_pos, [63:32] y_pos
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] brightness
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [31:0] cfg_wdata
);

	localparam int KW = epe_pkg::FRAC_IDX_W;

	epe_pkg::cfg_t cfg_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= epe_pkg::CFG_RESET;
		end else if (cfg_we) begin
			case (epe_pkg::reg_idx_t'(cfg_addr))
				epe_pkg::REG_MODE:        cfg_q.mode        <= cfg_wdata[0];
				epe_pkg::REG_CENTER_X:    cfg_q.center_x    <= cfg_wdata;
				epe_pkg::REG_CENTER_Y:    cfg_q.center_y    <= cfg_wdata;
				epe_pkg::REG_COS_ANGLE:   cfg_q.cos_angle   <= cfg_wdata[15:0];
				epe_pkg::REG_SIN_ANGLE:   cfg_q.sin_angle   <= cfg_wdata[15:0];
				epe_pkg::REG_INV_Q_SQ:    cfg_q.inv_q_sq    <= cfg_wdata[24:0];
				epe_pkg::REG_AMPLITUDE:   cfg_q.amplitude   <= cfg_wdata[15:0];
				epe_pkg::REG_SHAPE_PARAM: cfg_q.shape_param <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// stages 1..6: centre, rotate, square, weight, sum
	logic        r_valid;
	logic        r_ready;
	logic [46:0] r_rsq;

	epe_radius u_radius (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.x_pos     (s_tdata[31:0]),
		.y_pos     (s_tdata[63:32]),
		.out_valid (r_valid),
		.out_ready (r_ready),
		.rsq       (r_rsq)
	);

	// stages 7..11: exponent product, table lookup, scale, round
	logic v_s7, v_s8, v_s9, v_s10, v_s11;
	logic en_s7, en_s8, en_s9, en_s10, en_s11;

	logic            hit_s7, big_s7;
	logic [49:0]     ph_s7, pl_s7;
	logic            hit_s8, zero_s8;
	logic [3:0]      ip_s8;
	logic [KW-1:0]   k_s8;
	logic            hit_s9, zero_s9;
	logic [32:0]     m1_s9;
	logic [16:0]     ef_s9;
	logic            hit_s10, zero_s10;
	logic [49:0]     p_s10;
	logic [15:0]     bright_s11;

	logic [67:0]     tprod;
	logic [19:0]     t_q16;
	logic [16+KW-1:0] fk;
	logic [50:0]     rnd;
	logic [15:0]     gauss;

	assign en_s11  = !v_s11 || m_tready;
	assign en_s10  = !v_s10 || en_s11;
	assign en_s9   = !v_s9  || en_s10;
	assign en_s8   = !v_s8  || en_s9;
	assign en_s7   = !v_s7  || en_s8;
	assign r_ready = en_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else begin
			if (en_s7)  v_s7  <= r_valid;
			if (en_s8)  v_s8  <= v_s7;
			if (en_s9)  v_s9  <= v_s8;
			if (en_s10) v_s10 <= v_s9;
			if (en_s11) v_s11 <= v_s10;
		end
	end

	always_comb begin
		// only rsq[35:0] is used here (big_s7 flags larger rsq), so t = rsq*shape split over two 18-bit halves
		tprod = {ph_s7, 18'd0} + {18'd0, pl_s7};
		t_q16 = tprod[35:16];
		fk    = {{KW{1'b0}}, t_q16[15:0]} * (16 + KW)'(epe_pkg::FRAC_TABLE_DEPTH);
		rnd   = {1'b0, p_s10} + (51'd1 << 31);
		gauss = (rnd[50:48] != 3'd0) ? 16'hFFFF : rnd[47:32];
	end

	always_ff @(posedge clk) begin
		if (en_s7) begin
			hit_s7 <= ({15'd0, cfg_q.shape_param} > r_rsq);
			// rsq of 2^36 or more with nonzero shape: exponent at least 16
			big_s7 <= (r_rsq[46:36] != 11'd0) && (cfg_q.shape_param != 32'd0);
			ph_s7  <= r_rsq[35:18] * cfg_q.shape_param;
			pl_s7  <= r_rsq[17:0] * cfg_q.shape_param;
		end
		if (en_s8) begin
			hit_s8  <= hit_s7;
			zero_s8 <= big_s7 || (tprod[67:36] != 32'd0);
			ip_s8   <= t_q16[19:16];
			k_s8    <= fk[16+KW-1:16];
		end
		if (en_s9) begin
			hit_s9  <= hit_s8;
			zero_s9 <= zero_s8;
			m1_s9   <= cfg_q.amplitude * epe_pkg::INT_EXP_TAB[ip_s8];
			ef_s9   <= epe_pkg::FRAC_EXP_TAB[k_s8];
		end
		if (en_s10) begin
			hit_s10  <= hit_s9;
			zero_s10 <= zero_s9;
			p_s10    <= m1_s9 * ef_s9;
		end
		if (en_s11) begin
			if (!cfg_q.mode) begin
				bright_s11 <= hit_s10 ? cfg_q.amplitude : 16'd0;
			end else begin
				bright_s11 <= zero_s10 ? 16'd0 : gauss;
			end
		end
	end

	assign m_tvalid = v_s11;
	assign m_tdata  = bright_s11;

	a_tophat_levels: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !cfg_q.mode) |-> (m_tdata == 16'd0 || m_tdata == cfg_q.amplitude))
		else $error("top-hat output is neither zero nor amplitude");

	a_gauss_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && cfg_q.mode) |-> (m_tdata <= cfg_q.amplitude))
		else $error("Gaussian output above amplitude");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!r_ready |-> (v_s7 && v_s8 && v_s9 && v_s10 && v_s11))
		else $error("back end refuses a beat with an empty stage");

endmodule

@@ hdl/epe_radius.sv @@
// Position to elliptical radius squared, six pipeline stages.
module epe_radius (
	input  logic               clk,
	input  logic               arst_n,
	input  epe_pkg::cfg_t      cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] x_pos,
	input  logic signed [31:0] y_pos,
	output logic               out_valid,
	input  logic               out_ready,
	output logic        [46:0] rsq
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;

	logic signed [32:0] dx_s1, dy_s1;
	logic signed [48:0] dxc_s2, dys_s2, dyc_s2, dxs_s2;
	logic        [35:0] au_s3, av_s3;
	logic        [46:0] t1_s4, v2_s4;
	logic        [46:0] t1_s5;
	logic        [62:0] t2p_s5;
	logic               t2sat_s5;
	logic        [46:0] rsq_s6;

	logic signed [49:0] su, sv;
	logic        [35:0] u, v;
	logic        [61:0] uu, vv;
	logic        [46:0] t2;
	logic        [47:0] rsum;

	// stall chain: a stage loads when it is empty or its successor loads
	assign en_s6    = !v_s6 || out_ready;
	assign en_s5    = !v_s5 || en_s6;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	always_comb begin
		su = {dxc_s2[48], dxc_s2} + {dys_s2[48], dys_s2};
		sv = {dyc_s2[48], dyc_s2} - {dxs_s2[48], dxs_s2};
		// arithmetic shift by 14 is the floor
		u  = su[49:14];
		v  = sv[49:14];
		uu = au_s3[30:0] * au_s3[30:0];
		vv = av_s3[30:0] * av_s3[30:0];
		t2 = t2sat_s5 ? epe_pkg::RSQ_CAP : t2p_s5[62:16];
		rsum = {1'b0, t1_s5} + {1'b0, t2};
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			dx_s1 <= {x_pos[31], x_pos} - {cfg.center_x[31], cfg.center_x};
			dy_s1 <= {y_pos[31], y_pos} - {cfg.center_y[31], cfg.center_y};
		end
		if (en_s2) begin
			dxc_s2 <= dx_s1 * $signed(cfg.cos_angle);
			dys_s2 <= dy_s1 * $signed(cfg.sin_angle);
			dyc_s2 <= dy_s1 * $signed(cfg.cos_angle);
			dxs_s2 <= dx_s1 * $signed(cfg.sin_angle);
		end
		if (en_s3) begin
			au_s3 <= u[35] ? 36'(~u + 36'd1) : u;
			av_s3 <= v[35] ? 36'(~v + 36'd1) : v;
		end
		if (en_s4) begin
			t1_s4 <= (au_s3[35:31] != 5'd0) ? epe_pkg::RSQ_CAP : {1'b0, uu[61:16]};
			v2_s4 <= (av_s3[35:31] != 5'd0) ? epe_pkg::RSQ_CAP : {1'b0, vv[61:16]};
		end
		if (en_s5) begin
			t1_s5    <= t1_s4;
			t2sat_s5 <= (v2_s4[46:38] != 9'd0);
			t2p_s5   <= v2_s4[37:0] * cfg.inv_q_sq;
		end
		if (en_s6) begin
			rsq_s6 <= rsum[47] ? epe_pkg::RSQ_CAP : rsum[46:0];
		end
	end

	assign out_valid = v_s6;
	assign rsq       = rsq_s6;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6))
		else $error("radius pipe stalls input with an empty stage");

	a_u_overflow_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		(en_s4 && v_s3 && au_s3[35:31] != 5'd0) |=> (t1_s4 == epe_pkg::RSQ_CAP))
		else $error("large u did not saturate the first term");

	a_v_overflow_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		(en_s4 && v_s3 && av_s3[35:31] != 5'd0) |=> (v2_s4 == epe_pkg::RSQ_CAP))
		else $error("large v did not saturate its square");

endmodule

@@ tb/elliptical_profile_evaluator_test.sv @@
module elliptical_profile_evaluator_test;

	localparam int          DEPTH         = epe_pkg::FRAC_TABLE_DEPTH;
	localparam logic [63:0] SQ_SAT        = 64'h0000_7FFF_FFFF_FFFF; // 2^47 - 1
	localparam logic [63:0] EXPO_MAX      = 64'h0000_000F_FFFF_FFFF; // t below 16, unscaled
	localparam int          CYCLE_LIMIT   = 200000;
	localparam int          RANDOM_PHASES = 8;
	localparam int          PHASE_PIXELS  = 250;
	localparam int          DRAIN_CYCLES  = 24;  // 11-stage pipe plus margin
	localparam int          LONG_STALL    = 300;

	// exp(-i) in Q0.16 for the whole part of the exponent
	localparam logic [16:0] EXP_WHOLE [16] = '{
		17'd65536, 17'd24109, 17'd8869, 17'd3263, 17'd1200, 17'd442, 17'd162, 17'd60,
		17'd22,    17'd8,     17'd3,    17'd1,    17'd0,    17'd0,   17'd0,   17'd0
	};

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata   = '0;     // [31:0] x_pos, [63:32] y_pos
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;            // [15:0] brightness
	logic        cfg_we    = 1'b0;
	epe_pkg::reg_idx_t cfg_addr = epe_pkg::REG_MODE;
	logic [31:0] cfg_wdata = '0;

	// Shadow copy of the profile registers, as the block should hold them
	logic        prof_mode;
	logic [31:0] prof_cx;
	logic [31:0] prof_cy;
	logic [15:0] prof_cos;
	logic [15:0] prof_sin;
	logic [24:0] prof_inv_q2;
	logic [15:0] prof_amp;
	logic [31:0] prof_shape;

	logic [16:0] exp_frac_tab [DEPTH];

	logic [63:0] pixel_q [$];        // pixels waiting to be sent, {y, x}
	logic [15:0] brightness_q [$];   // predicted brightness, oldest first

	int send_idle_pct = 21;
	int recv_idle_pct = 77;
	bit send_hold     = 1'b0;
	int stall_left    = 0;
	bit pixel_taken   = 1'b0;
	int mismatch_count = 0;
	int cycle_count    = 0;

	elliptical_profile_evaluator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	// round(exp(-n/DEPTH) * 2^16): alternating Taylor series kept in Q.31
	function automatic logic [16:0] exp_neg_frac(int n);
		logic [63:0] x;
		logic [63:0] term;
		logic [63:0] plus;
		logic [63:0] minus;
		int          j;
		if (n == 0) return 17'd65536;
		x     = (64'(n) << 31) / 64'(DEPTH);
		term  = 64'd1 << 31;
		plus  = term;
		minus = 64'd0;
		for (j = 1; j <= 24; j++) begin
			term = ((term * x) >> 31) / 64'(j);
			if (j % 2 == 1) begin
				minus = minus + term;
			end else begin
				plus = plus + term;
			end
		end
		if (minus >= plus) return 17'd0;
		return 17'(((plus - minus) + (64'd1 << 14)) >> 15);
	endfunction

	// Brightness at one pixel under the current shadow registers
	function automatic logic [15:0] brightness_at(logic [31:0] xq, logic [31:0] yq);
		longint      dx;
		longint      dy;
		longint      c;
		longint      s;
		longint      u;
		longint      v;
		logic [63:0] au;
		logic [63:0] av;
		logic [63:0] t1;
		logic [63:0] t2;
		logic [63:0] v2;
		logic [63:0] rsq;
		logic [63:0] t;
		logic [63:0] p;
		logic [63:0] res;
		logic [3:0]  ip;
		int          k;
		dx = longint'($signed(xq)) - longint'($signed(prof_cx));
		dy = longint'($signed(yq)) - longint'($signed(prof_cy));
		c  = longint'($signed(prof_cos));
		s  = longint'($signed(prof_sin));
		// rotate, Q1.14 coefficients, floor back to Q.16
		u  = (dx * c + dy * s) >>> 14;
		v  = (dy * c - dx * s) >>> 14;
		au = (u < 0) ? -u : u;
		av = (v < 0) ? -v : v;
		t1 = (au >= 64'h8000_0000) ? SQ_SAT : (au * au) >> 16;
		v2 = (av >= 64'h8000_0000) ? SQ_SAT : (av * av) >> 16;
		if (v2 >= 64'h0000_0040_0000_0000) begin
			t2 = SQ_SAT;
		end else begin
			t2 = (v2 * 64'(prof_inv_q2)) >> 16;
			if (t2 > SQ_SAT) t2 = SQ_SAT;
		end
		rsq = t1 + t2;
		if (rsq > SQ_SAT) rsq = SQ_SAT;

		if (prof_mode == 1'b0) begin
			res = (rsq < 64'(prof_shape)) ? 64'(prof_amp) : 64'd0;
		end else if (rsq != 64'd0 && 64'(prof_shape) > EXPO_MAX / rsq) begin
			res = 64'd0;  // exponent of 16 or more
		end else begin
			t   = (rsq * 64'(prof_shape)) >> 16;
			ip  = t[19:16];
			k   = int'(((t & 64'hFFFF) * 64'(DEPTH)) >> 16);
			p   = 64'(prof_amp) * 64'(EXP_WHOLE[ip]) * 64'(exp_frac_tab[k]);
			res = (p + 64'h8000_0000) >> 32;
		end
		if (res > 64'hFFFF) res = 64'hFFFF;
		return res[15:0];
	endfunction

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		mismatch_count++;
		$display("MISMATCH %s: brightness %0d, predicted %0d (cycle %0d)",
			what, got, want, cycle_count);
	endtask

	// One register write per call; cfg_we stays up across back-to-back calls
	task automatic write_reg(epe_pkg::reg_idx_t idx, logic [31:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= data;
		case (idx)
			epe_pkg::REG_MODE:        prof_mode   = data[0];
			epe_pkg::REG_CENTER_X:    prof_cx     = data;
			epe_pkg::REG_CENTER_Y:    prof_cy     = data;
			epe_pkg::REG_COS_ANGLE:   prof_cos    = data[15:0];
			epe_pkg::REG_SIN_ANGLE:   prof_sin    = data[15:0];
			epe_pkg::REG_INV_Q_SQ:    prof_inv_q2 = data[24:0];
			epe_pkg::REG_AMPLITUDE:   prof_amp    = data[15:0];
			epe_pkg::REG_SHAPE_PARAM: prof_shape  = data;
			default: ;
		endcase
	endtask

	task automatic write_profile(logic [31:0] mode_w, logic [31:0] cx, logic [31:0] cy,
			logic [31:0] cos_w, logic [31:0] sin_w, logic [31:0] inv_w,
			logic [31:0] amp_w, logic [31:0] shape_w);
		write_reg(epe_pkg::REG_MODE, mode_w);
		write_reg(epe_pkg::REG_CENTER_X, cx);
		write_reg(epe_pkg::REG_CENTER_Y, cy);
		write_reg(epe_pkg::REG_COS_ANGLE, cos_w);
		write_reg(epe_pkg::REG_SIN_ANGLE, sin_w);
		write_reg(epe_pkg::REG_INV_Q_SQ, inv_w);
		write_reg(epe_pkg::REG_AMPLITUDE, amp_w);
		write_reg(epe_pkg::REG_SHAPE_PARAM, shape_w);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_pixel(logic [31:0] x, logic [31:0] y);
		pixel_q.push_back({y, x});
	endtask

	// Block is idle once nothing is queued, offered or outstanding
	task automatic wait_idle();
		while (pixel_q.size() != 0 || s_tvalid || brightness_q.size() != 0)
			@(negedge clk);
	endtask

	// Random profile; e sets the pixel spread (2^e pixels) the shape is tuned to.
	// Upper write-data bits beyond each register are filled with noise.
	task automatic random_profile(bit gauss, int e);
		real                th;
		logic [15:0]        c16;
		logic [15:0]        s16;
		logic [31:0]        inv;
		logic [31:0]        shp;
		logic [31:0]        cx;
		logic [31:0]        cy;
		logic signed [31:0] r;
		th  = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
		c16 = 16'($rtoi($floor(16384.0 * $cos(th) + 0.5)));
		s16 = 16'($rtoi($floor(16384.0 * $sin(th) + 0.5)));
		if ($urandom_range(9) == 0) begin
			c16 = 16'($urandom());  // not a true rotation
			s16 = 16'($urandom());
		end
		if ($urandom_range(7) == 0) begin
			case ($urandom_range(3))
				0:       inv = 32'd0;
				1:       inv = 32'd65535;
				2:       inv = 32'd16777216;
				default: inv = 32'h01FF_FFFF;
			endcase
		end else begin
			inv = $urandom_range(65536, 65536 * 16);
		end
		if (gauss) begin
			shp = $urandom_range(0, 1 << (21 - 2 * e));
		end else begin
			shp = $urandom_range(0, 1 << (17 + 2 * e));
		end
		if ($urandom_range(7) == 0) shp = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
		r = $urandom();
		if ($urandom_range(3) != 0) r = r >>> 3;
		cx = r;
		r = $urandom();
		if ($urandom_range(3) != 0) r = r >>> 3;
		cy = r;
		write_profile(($urandom() & ~32'd1) | 32'(gauss), cx, cy,
			($urandom() & 32'hFFFF_0000) | 32'(c16),
			($urandom() & 32'hFFFF_0000) | 32'(s16),
			inv | ($urandom() & 32'hFE00_0000),
			32'($urandom_range(0, 65535)) | ($urandom() & 32'hFFFF_0000),
			shp);
	endtask

	// Mostly pixels around the center, some further out, a few anywhere
	task automatic queue_pixels(int n, int e);
		logic signed [31:0] r;
		logic signed [31:0] off;
		logic [31:0]        x;
		logic [31:0]        y;
		int                 sel;
		int                 span;
		int                 i;
		for (i = 0; i < n; i++) begin
			sel = $urandom_range(9);
			if (sel == 9) begin
				x = $urandom();
				y = $urandom();
			end else begin
				span = (sel < 7) ? 16 + e : 20 + e;
				r    = $urandom();
				off  = r >>> (31 - span);
				x    = prof_cx + off;
				r    = $urandom();
				off  = r >>> (31 - span);
				y    = prof_cy + off;
			end
			push_pixel(x, y);
		end
	endtask

	// Sender: holds a beat until taken, otherwise offers the next pixel
	// unless idling or held back. Updated at once so that the idle check
	// at the same falling edge sees a beat that was just popped.
	always @(negedge clk) begin : driver
		if (arst_n && !(s_tvalid && !pixel_taken)) begin
			if (pixel_q.size() != 0 && !send_hold && $urandom_range(99) >= send_idle_pct) begin
				s_tdata  = pixel_q.pop_front();
				s_tvalid = 1'b1;
			end else begin
				s_tvalid = 1'b0;
			end
		end
		pixel_taken = 1'b0;
	end

	// Receiver: random back-pressure, plus a long hold-off on request
	always @(negedge clk) begin : receiver
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Monitor: check output beats first, then predict for accepted input beats
	always @(posedge clk) begin : monitor
		logic [15:0] want;
		if (m_tvalid && m_tready) begin
			if (brightness_q.size() == 0) begin
				report_mismatch("beat with no prediction", m_tdata, 16'd0);
			end else begin
				want = brightness_q.pop_front();
				if (m_tdata !== want) report_mismatch("brightness", m_tdata, want);
			end
		end
		if (s_tvalid && s_tready) begin
			brightness_q.push_back(brightness_at(s_tdata[31:0], s_tdata[63:32]));
			pixel_taken = 1'b1;
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("elliptical_profile_evaluator test failed");
			$finish;
		end
	end

	initial begin : sequencer
		int e;
		int k;
		for (k = 0; k < DEPTH; k++) exp_frac_tab[k] = exp_neg_frac(k);
		prof_mode   = 1'b1;
		prof_cx     = 32'd0;
		prof_cy     = 32'd0;
		prof_cos    = 16'd16384;
		prof_sin    = 16'd0;
		prof_inv_q2 = 25'd65536;
		prof_amp    = 16'd0;
		prof_shape  = 32'd0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset values: Gaussian, zero amplitude, so everything is dark
		push_pixel(32'd0, 32'd0);
		push_pixel(32'h7FFF_FFFF, 32'h8000_0000);
		wait_idle();

		// Round Gaussian, t = r^2: peak, whole and fractional exponents,
		// just under and exactly at the cut-off of 16, saturated corner
		write_profile(32'd1, 32'd0, 32'd0, 32'd16384, 32'd0, 32'd65536, 32'd65535, 32'd65536);
		push_pixel(32'd0, 32'd0);
		push_pixel(32'h0001_0000, 32'd0);
		push_pixel(32'd0, 32'h0001_8000);
		push_pixel(32'h0003_FFFF, 32'd0);
		push_pixel(32'h0004_0000, 32'd0);
		push_pixel(32'hFFFF_FFFF, 32'd0);
		push_pixel(32'h8000_0000, 32'h7FFF_FFFF);
		wait_idle();

		// Top-hat, radius 2, axis ratio 1/2, rotated 90 degrees, center (5, -3):
		// inside, on the edge (not lit), just inside, outside, far corner
		write_profile(32'hFFFF_FFFE, 32'h0005_0000, 32'hFFFD_0000, 32'd0, 32'd16384,
			32'h0004_0000, 32'd1234, 32'h0004_0000);
		push_pixel(32'h0005_0000, 32'hFFFD_0000);
		push_pixel(32'h0007_0000, 32'hFFFD_0000);
		push_pixel(32'h0005_0000, 32'hFFFF_0000);
		push_pixel(32'h0005_0000, 32'hFFFE_FFFF);
		push_pixel(32'h0005_FFFF, 32'hFFFD_0000);
		push_pixel(32'h0006_0000, 32'hFFFD_0000);
		push_pixel(32'h8000_0000, 32'h8000_0000);
		wait_idle();

		// Extreme registers: centers at the limits, coefficients out of range,
		// inverse axis ratio zero, widest shape
		write_profile(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_8000, 32'h0000_7FFF,
			32'd0, 32'h0000_FFFF, 32'hFFFF_FFFF);
		push_pixel(32'h8000_0000, 32'h7FFF_FFFF);
		push_pixel(32'h8000_0001, 32'h7FFF_FFFF);
		push_pixel(32'h7FFF_FFFF, 32'h8000_0000);
		wait_idle();

		// Largest inverse axis ratio (upper write bits dropped), zero shape:
		// exponent is zero even with a saturated radius
		write_profile(32'd1, 32'd0, 32'd0, 32'd16384, 32'd0, 32'hFFFF_FFFF, 32'd40000, 32'd0);
		push_pixel(32'h7FFF_FFFF, 32'h8000_0000);
		push_pixel(32'h1234_5678, 32'h9ABC_DEF0);
		push_pixel(32'd0, 32'd0);
		wait_idle();

		for (k = 0; k < RANDOM_PHASES; k++) begin
			if (k == 3) begin
				send_idle_pct = 77;
				recv_idle_pct = 21;
			end else if (k == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			e = $urandom_range(0, 6);
			random_profile(k % 2 == 0, e);
			if (k == 4) begin
				// half the beats, then hold the sender until every result is back
				queue_pixels(PHASE_PIXELS / 2, e);
				while (pixel_q.size() != 0) @(negedge clk);
				send_hold = 1'b1;
				queue_pixels(PHASE_PIXELS - PHASE_PIXELS / 2, e);
				while (s_tvalid || brightness_q.size() != 0) @(negedge clk);
				send_hold = 1'b0;
			end else begin
				queue_pixels(PHASE_PIXELS, e);
				if (k == 1) begin
					// receiver goes quiet while beats keep coming: pipe fills up
					@(posedge clk);
					stall_left = LONG_STALL;
				end
			end
			wait_idle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && brightness_q.size() == 0) begin
			$display("elliptical_profile_evaluator test passed");
		end else begin
			$display("elliptical_profile_evaluator test failed");
		end
		$finish;
	end

endmodule
